// File: hdl/scdr_pkg.sv
`default_nettype none

package scdr_pkg;

   localparam int ADDR_BITS      = 32;
   localparam int CHUNK_BITS     = 16;
   localparam int COUNT_BITS     = CHUNK_BITS + 1;
   localparam int BYTE_BITS      = 8;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [CHUNK_BITS-1:0] CHUNK_SIZE_RESET    = CHUNK_BITS'(8);
   localparam logic [ADDR_BITS-1:0]  REGION_LENGTH_RESET = ADDR_BITS'(4096);
   localparam logic                  REPORT_UNCHANGED_RESET = 1'b0;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CHUNK_SIZE       = 2'd0,
      CSR_REGION_LENGTH    = 2'd1,
      CSR_REPORT_UNCHANGED = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [CHUNK_BITS-1:0] chunk_size;
      logic [ADDR_BITS-1:0]  region_length;
      logic                  report_unchanged;
   } cfg_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0]  byte_position;
      logic [COUNT_BITS-1:0] bytes_in_chunk;
      logic [ADDR_BITS-1:0]  chunk_begin;
      logic                  chunk_mismatch;
      logic                  chunk_is_final;
      logic                  run_open;
      logic [ADDR_BITS-1:0]  open_run_start;
      logic [ADDR_BITS-1:0]  open_run_length;
   } state_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0] run_start;
      logic [ADDR_BITS-1:0] run_length;
      logic                 run_present;
      logic                 end_of_scan;
   } rsp_type;

endpackage

`default_nettype wire

// File: hdl/scdr_ifs.sv
`default_nettype none

interface scdr_req_if;
   logic                          valid;
   logic                          ready;
   logic [scdr_pkg::BYTE_BITS-1:0] old_byte;
   logic [scdr_pkg::BYTE_BITS-1:0] new_byte;

   modport source (output valid, output old_byte, output new_byte, input ready);
   modport sink   (input valid, input old_byte, input new_byte, output ready);
endinterface

interface scdr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [scdr_pkg::ADDR_BITS-1:0] run_start;
   logic [scdr_pkg::ADDR_BITS-1:0] run_length;
   logic                          run_present;
   logic                          end_of_scan;

   modport source (output valid, output run_start, output run_length,
                   output run_present, output end_of_scan, input ready);
   modport sink   (input valid, input run_start, input run_length,
                   input run_present, input end_of_scan, output ready);
endinterface

interface scdr_csr_if;
   logic                               valid;
   logic                               ready;
   logic [scdr_pkg::CSR_INDEX_BITS-1:0] index;
   logic [scdr_pkg::CSR_DATA_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hdl/scdr_step.sv
`default_nettype none

// Next-state and result logic for one byte pair.
module scdr_step (
   input  scdr_pkg::cfg_type                  cfg_i,
   input  scdr_pkg::state_type                state_i,
   input  logic [scdr_pkg::BYTE_BITS-1:0]     old_byte_i,
   input  logic [scdr_pkg::BYTE_BITS-1:0]     new_byte_i,
   output scdr_pkg::state_type                state_o,
   output scdr_pkg::rsp_type                  rsp_o,
   output logic                               emit_o
);
   import scdr_pkg::*;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   logic                  first_byte;
   logic [ADDR_BITS-1:0]  begin_eff;
   logic                  final_eff;
   logic [ADDR_BITS-1:0]  remain;
   logic [ADDR_BITS:0]    two_csz;
   logic [ADDR_BITS:0]    pos_inc;
   logic                  mm;
   logic [COUNT_BITS-1:0] cnt;
   logic                  last;
   logic                  short_region;
   logic                  close_chunk;
   logic [ADDR_BITS-1:0]  csize;
   logic                  hit;
   logic                  emit_close;
   logic                  run_open_n;
   logic [ADDR_BITS-1:0]  run_start_n;
   logic [ADDR_BITS-1:0]  run_length_n;

   always_comb begin
      first_byte = (state_i.bytes_in_chunk == '0);
      remain     = cfg_i.region_length - state_i.byte_position;
      two_csz    = {{(ADDR_BITS-CHUNK_BITS){1'b0}}, cfg_i.chunk_size, 1'b0};
      begin_eff  = first_byte ? state_i.byte_position : state_i.chunk_begin;
      if (first_byte) begin
         final_eff = (state_i.byte_position >= cfg_i.region_length) ||
                     ({1'b0, remain} < two_csz);
      end else begin
         final_eff = state_i.chunk_is_final;
      end
      mm  = (state_i.chunk_mismatch && !first_byte) || (old_byte_i != new_byte_i);
      cnt = (state_i.bytes_in_chunk == COUNT_MAX) ? COUNT_MAX
                                                  : state_i.bytes_in_chunk + 1'b1;

      pos_inc      = {1'b0, state_i.byte_position} + 1'b1;
      last         = (pos_inc >= {1'b0, cfg_i.region_length});
      short_region = (cfg_i.chunk_size == '0) ||
                     (cfg_i.region_length <
                      {{(ADDR_BITS-CHUNK_BITS){1'b0}}, cfg_i.chunk_size});
      close_chunk  = !short_region &&
                     (last || (!final_eff && (cnt >= {1'b0, cfg_i.chunk_size})));
      csize        = pos_inc[ADDR_BITS-1:0] - begin_eff;
      hit          = cfg_i.report_unchanged ? !mm : mm;

      run_open_n   = state_i.run_open;
      run_start_n  = state_i.open_run_start;
      run_length_n = state_i.open_run_length;
      emit_close   = close_chunk && !hit && state_i.run_open;
      if (close_chunk && hit) begin
         if (state_i.run_open) begin
            run_length_n = state_i.open_run_length + csize;
         end else begin
            run_open_n   = 1'b1;
            run_start_n  = begin_eff;
            run_length_n = csize;
         end
      end
      if (emit_close) begin
         run_open_n = 1'b0;
      end

      // A result that carries no run shows zero start and length.
      rsp_o = '0;
      if (emit_close) begin
         rsp_o.run_present = 1'b1;
         rsp_o.run_start   = state_i.open_run_start;
         rsp_o.run_length  = state_i.open_run_length;
         rsp_o.end_of_scan = last;
      end else if (last) begin
         rsp_o.run_present = run_open_n;
         rsp_o.run_start   = run_open_n ? run_start_n : '0;
         rsp_o.run_length  = run_open_n ? run_length_n : '0;
         rsp_o.end_of_scan = 1'b1;
      end
      emit_o = emit_close || last;

      if (last) begin
         state_o = '0;
      end else begin
         state_o.byte_position   = pos_inc[ADDR_BITS-1:0];
         state_o.bytes_in_chunk  = close_chunk ? '0 : cnt;
         state_o.chunk_begin     = begin_eff;
         state_o.chunk_mismatch  = close_chunk ? 1'b0 : mm;
         state_o.chunk_is_final  = final_eff;
         state_o.run_open        = run_open_n;
         state_o.open_run_start  = run_start_n;
         state_o.open_run_length = run_length_n;
      end
   end

endmodule

`default_nettype wire

// File: hdl/snapshot_chunk_diff_runs.sv
// A byte pair is captured in the input register, and its result, if any, is then registered in
// the result register, from which it transfers on the output.
// Throughput: one byte pair per cycle. While a result waits on the output, one more byte pair
// is taken into the input register, and then the input stalls until the result transfers.
// Reset (synchronous, active high) restores the register defaults (chunk size 8, region length
// 4096, changed-run mode), clears the scan state and any open run, and empties both registers.
`default_nettype none

module snapshot_chunk_diff_runs (
   input  logic       clock,
   input  logic       reset,
   scdr_req_if.sink   req_ch,
   scdr_rsp_if.source rsp_ch,
   scdr_csr_if.sink   csr_ch
);
   import scdr_pkg::*;

   // Configuration registers. Writes are always taken; the user only writes them
   // while the block is idle.
   cfg_type cfg_ff;

   // Scan state: position in the region, the chunk under comparison, and the run
   // that is still being extended.
   state_type state_ff;
   state_type state_in;

   // Input register. It holds one byte pair until the result register can take
   // whatever that byte produces.
   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   logic [BYTE_BITS-1:0] s1_old_ff;
   logic [BYTE_BITS-1:0] s1_new_ff;

   // Result register.
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_ff;

   rsp_type step_rsp;
   logic    step_emit;
   logic    out_free;
   logic    s1_go;
   logic    req_transfer;

   // The stage advances whenever the result register is empty or is being
   // drained in this cycle, whether or not the byte produces a result.
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign s1_go        = s1_valid_ff && out_free;
   assign req_ch.ready = !s1_valid_ff || s1_go;
   assign req_transfer = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   scdr_step u_step (
      .cfg_i      (cfg_ff),
      .state_i    (state_ff),
      .old_byte_i (s1_old_ff),
      .new_byte_i (s1_new_ff),
      .state_o    (state_in),
      .rsp_o      (step_rsp),
      .emit_o     (step_emit)
   );

   always_comb begin
      if (req_transfer) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end

      if (s1_go) begin
         rsp_valid_in = step_emit;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.chunk_size       <= CHUNK_SIZE_RESET;
         cfg_ff.region_length    <= REGION_LENGTH_RESET;
         cfg_ff.report_unchanged <= REPORT_UNCHANGED_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_CHUNK_SIZE: begin
               cfg_ff.chunk_size <= csr_ch.data[CHUNK_BITS-1:0];
            end
            CSR_REGION_LENGTH: begin
               cfg_ff.region_length <= csr_ch.data[ADDR_BITS-1:0];
            end
            CSR_REPORT_UNCHANGED: begin
               cfg_ff.report_unchanged <= csr_ch.data[0];
            end
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_go) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_transfer) begin
         s1_old_ff <= req_ch.old_byte;
         s1_new_ff <= req_ch.new_byte;
      end
      if (s1_go && step_emit) begin
         rsp_ff <= step_rsp;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.run_start   = rsp_ff.run_start;
   assign rsp_ch.run_length  = rsp_ff.run_length;
   assign rsp_ch.run_present = rsp_ff.run_present;
   assign rsp_ch.end_of_scan = rsp_ff.end_of_scan;

   // A result without a run never shows stale start or length values.
   a_no_run_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.run_present) |->
         (rsp_ff.run_start == '0 && rsp_ff.run_length == '0))
      else $error("result without a run carries nonzero start or length");

   // The region's final byte restarts the scan from offset zero with no open run.
   a_scan_restart : assert property (@(posedge clock) disable iff (reset)
      (s1_go && step_emit && step_rsp.end_of_scan) |=>
         (state_ff.byte_position == '0 && state_ff.bytes_in_chunk == '0 &&
          !state_ff.run_open))
      else $error("scan state not cleared after end of scan");

   // A byte held in the input register is not dropped while the output is blocked.
   a_stage_holds : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |=> s1_valid_ff)
      else $error("input register lost a byte while the output was stalled");

endmodule

`default_nettype wire
